@@ rtl/core/pllc_pkg.sv @@
// Shared types and constants for the power-law contrast curve.
package pllc_pkg;

   localparam int PixBits = 8;
   localparam logic [PixBits-1:0] PixMax = '1;

   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits  = 16;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_GAMMA_EXPONENT = 2'd0,
      CSR_PHASE_OFFSET   = 2'd1
   } csr_index_type;

   localparam logic [CsrDataBits-1:0] GammaReset = 16'd4096;
   localparam logic [CsrDataBits-1:0] PhaseReset = 16'd0;

   // Result class: computed, forced to zero or forced to full scale.
   typedef enum logic [1:0] {
      CLS_CALC,
      CLS_ZERO,
      CLS_FULL
   } cls_type;

   // log2 datapath.
   localparam int MantBits   = 31;
   localparam int FracBits   = 16;
   localparam int ExpIntBits = 6;
   localparam int LogSteps   = FracBits;

   // exp2 datapath: one square root per fraction bit.
   localparam int RootBits      = 31;
   localparam int RemBits       = 33;
   localparam int XBits         = 32;
   localparam int ShiftBits     = 4;
   localparam int SqrtPairs     = 31;
   localparam int PairsPerStage = 4;
   localparam int SqrtStages    = (SqrtPairs + PairsPerStage - 1) / PairsPerStage;
   localparam int ExpStages     = FracBits * SqrtStages;

   typedef struct packed {
      logic                  valid;
      cls_type               cls;
      logic [ExpIntBits-1:0] exp_int;
      logic [MantBits-1:0]   mant;
      logic [FracBits-1:0]   frac;
   } log_work_type;

   typedef struct packed {
      logic                 valid;
      cls_type              cls;
      logic [ShiftBits-1:0] shift;
      logic [FracBits-1:0]  frac;
      logic [XBits-1:0]     xbits;
      logic [RemBits-1:0]   rem;
      logic [RootBits-1:0]  root;
   } exp_work_type;

endpackage

@@ rtl/core/pllc_if.sv @@
// Channel interfaces for pixel input, pixel result and register writes.
interface pllc_req_if import pllc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PixBits-1:0] pixel_in;
   modport source (output valid, output pixel_in, input ready);
   modport sink (input valid, input pixel_in, output ready);
endinterface

interface pllc_rsp_if import pllc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PixBits-1:0] pixel_out;
   modport source (output valid, output pixel_out, input ready);
   modport sink (input valid, input pixel_out, output ready);
endinterface

interface pllc_csr_if import pllc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CsrIndexBits-1:0] index;
   logic [CsrDataBits-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/power_law_contrast_curve.sv @@
// Top level of the power-law contrast curve for 8-bit grayscale pixels.
//
//   Channel   Role     Beat contents
//   req_bus   sink     pixel_in  : 8-bit input pixel
//   rsp_bus   source   pixel_out : 8-bit adjusted pixel
//   csr_bus   sink     index, data : register write (0 exponent, 1 phase)
//
// One pixel beat is accepted per cycle unless a result waits on rsp_bus.
// The pipeline stages are: base, normalize, 16 log2 squaring
// stages, multiply, classify, 128 square-root stages (8 per root) and output.
// All stages advance together whenever the output register is empty or taken,
// so a stall on rsp_bus holds every beat in place; nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the register defaults.
module power_law_contrast_curve import pllc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pllc_req_if.sink  req_bus,
   pllc_rsp_if.source rsp_bus,
   pllc_csr_if.sink  csr_bus
);

   // Configuration registers.
   logic [CsrDataBits-1:0] gamma_ff;
   logic [CsrDataBits-1:0] phase_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GammaReset;
         phase_ff <= PhaseReset;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_GAMMA_EXPONENT: gamma_ff <= csr_bus.data;
            CSR_PHASE_OFFSET:   phase_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Global advance: the whole pipeline moves unless a finished result waits.
   logic en;
   logic rsp_valid_ff;
   logic [PixBits-1:0] pixel_out_ff;

   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   // Stage A: the base p/255 in Q16 plus twice the Q1.15 phase.
   // p*65536/255 rounded equals 257*p plus one when p is 128 or more.
   logic               a_valid_ff;
   cls_type            a_cls_ff;
   logic [18:0]        a_base_ff;
   logic [18:0]        a_base_in;

   assign a_base_in = 19'({req_bus.pixel_in, req_bus.pixel_in})
                    + 19'(req_bus.pixel_in[PixBits-1])
                    + {{2{phase_ff[CsrDataBits-1]}}, phase_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_bus.valid && req_bus.ready;
         a_cls_ff   <= (gamma_ff == '0) ? CLS_FULL : CLS_CALC;
         a_base_ff  <= a_base_in;
      end
   end

   // Stage B: find the leading one and normalize the mantissa into Q30.
   log_work_type b_ff;
   log_work_type b_in;

   always_comb begin
      logic [4:0] lead;
      lead = '0;
      for (int i = 0; i < 18; i++) begin
         if (a_base_ff[i]) begin
            lead = 5'(i);
         end
      end
      b_in.valid   = a_valid_ff;
      b_in.cls     = a_cls_ff;
      // A base of zero or below gives black once the exponent is nonzero.
      if (a_cls_ff == CLS_CALC && (a_base_ff[18] || a_base_ff == '0)) begin
         b_in.cls = CLS_ZERO;
      end
      b_in.exp_int = 6'(lead) - 6'd16;
      b_in.mant    = MantBits'({13'b0, a_base_ff[17:0]}) << (5'd30 - lead);
      b_in.frac    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else if (en) begin
         b_ff <= b_in;
      end
   end

   log_work_type log_out;

   pllc_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .log_in  (b_ff),
      .log_out (log_out)
   );

   // Stage C: multiply the Q16 logarithm by the Q4.12 exponent.
   logic               c_valid_ff;
   cls_type            c_cls_ff;
   logic signed [38:0] c_prod_ff;
   logic signed [21:0] c_log;
   logic signed [16:0] c_gamma;

   assign c_log   = $signed({log_out.exp_int, log_out.frac});
   assign c_gamma = $signed({1'b0, gamma_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= log_out.valid;
         c_cls_ff   <= log_out.cls;
         c_prod_ff  <= c_log * c_gamma;
      end
   end

   // Stage D: floor the product to Q16 and split it into shift and fraction.
   // A non-negative power saturates to white; below -9 it rounds to black.
   exp_work_type d_ff;
   exp_work_type d_in;

   always_comb begin
      logic signed [26:0] y;
      logic [19:0]        uy;
      y  = c_prod_ff[38:12];
      uy = 20'(y + 27'sd655360);
      d_in.valid = c_valid_ff;
      d_in.cls   = c_cls_ff;
      if (c_cls_ff == CLS_CALC) begin
         if (!y[26]) begin
            d_in.cls = CLS_FULL;
         end else if (y < -27'sd589824) begin
            d_in.cls = CLS_ZERO;
         end
      end
      d_in.shift = 4'd10 - uy[19:16];
      d_in.frac  = uy[15:0];
      d_in.xbits = '0;
      d_in.rem   = '0;
      d_in.root  = RootBits'(1) << 30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else if (en) begin
         d_ff <= d_in;
      end
   end

   exp_work_type exp_out;

   pllc_exp2 u_exp2 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .exp_in  (d_ff),
      .exp_out (exp_out)
   );

   // Output stage: scale the Q30 power by 255 and drop 30 plus shift bits.
   logic [PixBits-1:0] pixel_out_in;

   always_comb begin
      logic [38:0] scaled;
      logic [38:0] shifted;
      scaled  = {exp_out.root, 8'b0} - {8'b0, exp_out.root};
      shifted = scaled >> (6'd30 + 6'(exp_out.shift));
      case (exp_out.cls)
         CLS_FULL: pixel_out_in = PixMax;
         CLS_ZERO: pixel_out_in = '0;
         default:  pixel_out_in = (shifted > 39'(PixMax)) ? PixMax : shifted[PixBits-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= exp_out.valid;
         pixel_out_ff <= pixel_out_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pixel_out = pixel_out_ff;

endmodule

@@ rtl/core/pllc_log2.sv @@
// Pipelined log2 fraction: one mantissa squaring per stage.
module pllc_log2 import pllc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  log_work_type log_in,
   output log_work_type log_out
);

   log_work_type work_ff [LogSteps];

   genvar s;
   for (s = 0; s < LogSteps; s++) begin : g_step
      log_work_type                cur;
      log_work_type                work_in;
      logic [2*MantBits-1:0]       square;
      logic [MantBits:0]           square_hi;

      if (s == 0) begin : g_first
         assign cur = log_in;
      end else begin : g_next
         assign cur = work_ff[s-1];
      end

      always_comb begin
         square    = {{MantBits{1'b0}}, cur.mant} * {{MantBits{1'b0}}, cur.mant};
         square_hi = square[2*MantBits-1:MantBits-1];
         work_in   = cur;
         // A squared mantissa of two or more yields a one bit and is halved.
         if (square_hi[MantBits]) begin
            work_in.mant                = square_hi[MantBits:1];
            work_in.frac[LogSteps-1-s]  = 1'b1;
         end else begin
            work_in.mant = square_hi[MantBits-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            work_ff[s].valid <= 1'b0;
         end else if (en) begin
            work_ff[s] <= work_in;
         end
      end
   end

   assign log_out = work_ff[LogSteps-1];

endmodule

@@ rtl/core/pllc_exp2.sv @@
// Pipelined exp2 of the fraction: sixteen digit-recurrence square roots.
module pllc_exp2 import pllc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  exp_work_type exp_in,
   output exp_work_type exp_out
);

   exp_work_type work_ff [ExpStages];

   genvar s;
   for (s = 0; s < ExpStages; s++) begin : g_stage
      localparam int Root = s / SqrtStages;
      localparam int Part = s % SqrtStages;

      exp_work_type cur;
      exp_work_type work_in;

      if (s == 0) begin : g_first
         assign cur = exp_in;
      end else begin : g_next
         assign cur = work_ff[s-1];
      end

      always_comb begin
         logic [XBits-1:0]   seed;
         logic [RemBits+1:0] remw;
         logic [RemBits+1:0] trial;
         work_in = cur;
         seed    = '0;
         remw    = '0;
         trial   = '0;
         // The first stage of each root loads the previous root, doubled when
         // the matching fraction bit is set; the radicand is that value << 30.
         if (Part == 0) begin
            seed = XBits'(cur.root);
            if (cur.frac[Root]) begin
               seed = {seed[XBits-2:0], 1'b0};
            end
            work_in.xbits = seed;
            work_in.rem   = '0;
            work_in.root  = '0;
         end
         for (int n = 0; n < PairsPerStage; n++) begin
            if (Part * PairsPerStage + n < SqrtPairs) begin
               remw  = {work_in.rem, work_in.xbits[XBits-1 -: 2]};
               trial = (RemBits + 2)'({work_in.root, 2'b01});
               if (remw >= trial) begin
                  remw         = remw - trial;
                  work_in.root = {work_in.root[RootBits-2:0], 1'b1};
               end else begin
                  work_in.root = {work_in.root[RootBits-2:0], 1'b0};
               end
               work_in.rem   = remw[RemBits-1:0];
               work_in.xbits = {work_in.xbits[XBits-3:0], 2'b00};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            work_ff[s].valid <= 1'b0;
         end else if (en) begin
            work_ff[s] <= work_in;
         end
      end
   end

   assign exp_out = work_ff[ExpStages-1];

endmodule
